// ===== rtl/suffix_array_with_lcp_assert.svh =====
// Assertion macros for the suffix sorter.
// Used by the top level only.
`ifndef SUFFIX_ARRAY_WITH_LCP_ASSERT_SVH
`define SUFFIX_ARRAY_WITH_LCP_ASSERT_SVH
`define SA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/sa_pkg.sv =====
// Shared constants and types for the suffix sorter.
// No dependencies.
package sa_pkg;
  localparam int MaxLen = 63;
  localparam int PosW = 6;
  typedef logic [PosW-1:0] pos_t;
  typedef struct packed {
    logic load;
    logic start;
    logic place;
    logic shift_down;
    logic cmp_load;
    logic step;
    logic lcp_a;
    logic lcp_b;
    logic lcp_done;
    logic r_clear;
    logic rd_r;
    logic rd_next;
    logic emit;
    logic out_take;
  } sa_cmd_t;
  typedef struct packed {
    logic j_zero;
    logic i_last;
    logic r_last;
    logic diff;
    logic less;
    logic out_valid;
  } sa_sts_t;
endpackage

// ===== rtl/sa_datapath.sv =====
// Datapath of the suffix sorter: symbol memory, rank and prefix stores, compare unit.
// Depends on sa_pkg.
module sa_datapath (
  input  logic clk,
  input  logic rst,
  input  sa_pkg::sa_cmd_t cmd,
  input  logic [31:0] symbol,
  output sa_pkg::sa_sts_t sts,
  output sa_pkg::pos_t suffix_start,
  output sa_pkg::pos_t common_prefix,
  output logic final_rank
);
  import sa_pkg::*;
  logic [31:0] sym [MaxLen];
  pos_t rnk [MaxLen+1];
  pos_t pfx [MaxLen];
  pos_t cnt, n, i, j, a, b, h, r;
  pos_t rk_addr, pf_addr, sa_addr, sb_addr;
  pos_t rb, pb;
  logic [31:0] sa_d, sb_d;
  logic a_end, b_end;
  logic ov;

  assign rk_addr = cmd.rd_next ? r + 1'b1 : (cmd.rd_r ? r : j - 1'b1);
  assign pf_addr = (rk_addr == PosW'(MaxLen)) ? '0 : rk_addr;
  assign sa_addr = (a == PosW'(MaxLen)) ? '0 : a;
  assign sb_addr = (b == PosW'(MaxLen)) ? '0 : b;

  always_ff @(posedge clk) begin
    if (cmd.load && cnt < PosW'(MaxLen)) sym[cnt] <= symbol;
    sa_d <= sym[sa_addr];
    sb_d <= sym[sb_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.place) rnk[j] <= i;
    else if (cmd.shift_down) rnk[j] <= rb;
    rb <= rnk[rk_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.lcp_done) pfx[r] <= h;
    pb <= pfx[pf_addr];
  end

  always_ff @(posedge clk) begin
    a_end <= (a >= n);
    b_end <= (b >= n);
    if (rst) begin
      cnt <= '0;
      ov <= 1'b0;
    end else begin
      if (cmd.start) cnt <= '0;
      else if (cmd.load && cnt < PosW'(MaxLen)) cnt <= cnt + 1'b1;
      if (cmd.emit) ov <= 1'b1;
      else if (cmd.out_take) ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) n <= (cnt < PosW'(MaxLen)) ? cnt + 1'b1 : cnt;
    if (cmd.start) begin
      i <= '0;
      j <= '0;
    end else if (cmd.place) begin
      i <= i + 1'b1;
      j <= i + 1'b1;
    end else if (cmd.shift_down) begin
      j <= j - 1'b1;
    end
    if (cmd.cmp_load) begin
      a <= i;
      b <= rb;
    end else if (cmd.lcp_a) begin
      a <= rb;
    end else if (cmd.lcp_b) begin
      b <= rb;
    end else if (cmd.step) begin
      a <= a + 1'b1;
      b <= b + 1'b1;
    end
    if (cmd.lcp_b) h <= '0;
    else if (cmd.step) h <= h + 1'b1;
    if (cmd.start || cmd.r_clear) r <= '0;
    else if (cmd.lcp_done || cmd.emit) r <= r + 1'b1;
    if (cmd.emit) begin
      suffix_start <= rb;
      common_prefix <= (r == n) ? '0 : pb;
      final_rank <= (r == n);
    end
  end

  assign sts.j_zero = (j == '0);
  assign sts.i_last = (i == n);
  assign sts.r_last = (r == n);
  assign sts.diff = a_end || b_end || (sa_d != sb_d);
  assign sts.less = (!a_end && !b_end && ((sa_d ^ 32'h8000_0000) < (sb_d ^ 32'h8000_0000)))
                    || (a_end && !b_end);
  assign sts.out_valid = ov;
endmodule

// ===== rtl/sa_ctrl.sv =====
// Controller of the suffix sorter: handshakes and the sort, prefix and output sequence.
// Depends on sa_pkg.
module sa_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic end_of_string,
  input  logic out_stall,
  input  sa_pkg::sa_sts_t sts,
  output logic in_stall,
  output logic out_valid,
  output sa_pkg::sa_cmd_t cmd
);
  import sa_pkg::*;
  localparam logic [3:0] S_LOAD = 4'd0, S_INS = 4'd1, S_FETCH = 4'd2, S_READ = 4'd3,
                         S_CMP = 4'd4, S_LFA = 4'd5, S_LFB = 4'd6, S_LSET = 4'd7,
                         S_LREAD = 4'd8, S_LCMP = 4'd9, S_OUT = 4'd10, S_EMIT = 4'd11,
                         S_DONE = 4'd12;
  logic [3:0] state, state_next;
  logic acc;
  logic can_emit;
  assign in_stall = (state != S_LOAD);
  assign acc = in_valid && !in_stall;
  assign out_valid = sts.out_valid;
  assign can_emit = !sts.out_valid || !out_stall;
  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.load = acc;
    cmd.out_take = sts.out_valid && !out_stall;
    case (state)
      S_LOAD: begin
        if (acc && end_of_string) begin
          cmd.start = 1'b1;
          state_next = S_INS;
        end
      end
      S_INS: begin
        if (sts.j_zero) begin
          cmd.place = 1'b1;
          state_next = sts.i_last ? S_LFA : S_INS;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.cmp_load = 1'b1;
        state_next = S_READ;
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        if (!sts.diff) begin
          cmd.step = 1'b1;
          state_next = S_READ;
        end else if (sts.less) begin
          cmd.shift_down = 1'b1;
          state_next = S_INS;
        end else begin
          cmd.place = 1'b1;
          state_next = sts.i_last ? S_LFA : S_INS;
        end
      end
      S_LFA: begin
        if (sts.r_last) begin
          cmd.r_clear = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.rd_r = 1'b1;
          state_next = S_LFB;
        end
      end
      S_LFB: begin
        cmd.lcp_a = 1'b1;
        cmd.rd_next = 1'b1;
        state_next = S_LSET;
      end
      S_LSET: begin
        cmd.lcp_b = 1'b1;
        state_next = S_LREAD;
      end
      S_LREAD: state_next = S_LCMP;
      S_LCMP: begin
        if (sts.diff) begin
          cmd.lcp_done = 1'b1;
          state_next = S_LFA;
        end else begin
          cmd.step = 1'b1;
          state_next = S_LREAD;
        end
      end
      S_OUT: begin
        cmd.rd_r = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.rd_r = 1'b1;
        if (can_emit) begin
          cmd.emit = 1'b1;
          cmd.rd_next = 1'b1;
          if (sts.r_last) state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (can_emit) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end
endmodule

// ===== rtl/suffix_array_with_lcp.sv =====
// Top level of the suffix sorter with common prefix output.
// Depends on sa_pkg, sa_ctrl, sa_datapath and the assertion header.
//  channel | signals                                       | flow
//  input   | in_valid in_stall symbol end_of_string        | in
//  output  | out_valid out_stall suffix_start common_prefix final_rank | out
// Each symbol is stored as it is accepted. After the last symbol an insertion
// sort runs: each comparison fetches both suffixes and examines one symbol at a
// time, and each slot check or shift is a step of its own. The prefix pass then
// compares adjacent ranks; results follow one per cycle while not stalled.
// Input is stalled from the last symbol until the final result transfer; an
// output stall holds the result and pauses the block. Reset is synchronous.
module suffix_array_with_lcp (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [31:0] symbol,
  input  logic end_of_string,
  output logic out_valid,
  input  logic out_stall,
  output logic [5:0] suffix_start,
  output logic [5:0] common_prefix,
  output logic final_rank
);
  import sa_pkg::*;
  `include "suffix_array_with_lcp_assert.svh"
  sa_cmd_t cmd;
  sa_sts_t sts;
  sa_ctrl u_ctrl (.clk, .rst, .in_valid, .end_of_string, .out_stall, .sts,
                  .in_stall, .out_valid, .cmd);
  sa_datapath u_dp (.clk, .rst, .cmd, .symbol, .sts, .suffix_start,
                    .common_prefix, .final_rank);
  `SA_ASSERT_NEXT(a_start_stall, cmd.start, in_stall, "input taken after last symbol")
  `SA_ASSERT_IMPL(a_out_stall, out_valid, in_stall, "output while accepting")
  `SA_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "stalled result dropped")
  `SA_ASSERT_NEXT(a_out_keep, out_valid && out_stall, $stable(suffix_start), "result changed")
endmodule

// ===== tb/tb_suffix_array_with_lcp.sv =====
// Testbench for the suffix sorter with common prefix output.
// Depends on the suffix_array_with_lcp top level; it predicts every result itself.
module tb_suffix_array_with_lcp;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StoreDepth = 63;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [5:0] start;
    logic [5:0] prefix;
    logic       last;
  } rank_entry_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [31:0] symbol;
  logic end_of_string;
  logic out_valid;
  logic out_stall;
  logic [5:0] suffix_start;
  logic [5:0] common_prefix;
  logic final_rank;

  suffix_array_with_lcp DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .symbol(symbol), .end_of_string(end_of_string),
    .out_valid(out_valid), .out_stall(out_stall),
    .suffix_start(suffix_start), .common_prefix(common_prefix),
    .final_rank(final_rank)
  );

  logic signed [31:0] text[StoreDepth];
  int text_len;
  rank_entry_t ranked_q[$];
  int send_idle_pct;
  int stall_pct;
  int hold_cycles;
  int mismatch_count;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit suffix_before(int a, int b, int n);
    while (a < n && b < n) begin
      if (text[a] != text[b]) return text[a] < text[b];
      a++;
      b++;
    end
    return a >= n && b < n;
  endfunction

  function automatic int shared_len(int a, int b, int n);
    int h;
    h = 0;
    while (a + h < n && b + h < n && text[a + h] == text[b + h]) h++;
    return h;
  endfunction

  task automatic rank_suffixes();
    int order[StoreDepth + 1];
    int n;
    int j;
    int cur;
    rank_entry_t e;
    n = text_len;
    for (int i = 0; i <= n; i++) begin
      cur = i;
      j = i;
      while (j > 0 && suffix_before(cur, order[j - 1], n)) begin
        order[j] = order[j - 1];
        j--;
      end
      order[j] = cur;
    end
    for (int r = 0; r <= n; r++) begin
      e.start = order[r][5:0];
      e.prefix = (r < n) ? 6'(shared_len(order[r], order[r + 1], n)) : 6'd0;
      e.last = (r == n);
      ranked_q.push_back(e);
    end
    text_len = 0;
  endtask

  task automatic send_symbol(input logic [31:0] value, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    symbol <= value;
    end_of_string <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (text_len < StoreDepth) begin
      text[text_len] = value;
      text_len++;
    end
    if (eos) rank_suffixes();
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (ranked_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] random_symbol(int alphabet);
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($urandom_range(alphabet) - alphabet / 2);
      default: return 32'($urandom_range(alphabet - 1));
    endcase
  endfunction

  task automatic send_string(int len, int alphabet);
    for (int i = 0; i < len; i++) send_symbol(random_symbol(alphabet), i == len - 1);
  endtask

  task automatic test_directed();
    send_symbol(32'h8000_0000, 1'b1);
    send_symbol(32'h7fff_ffff, 1'b0);
    send_symbol(32'h8000_0000, 1'b0);
    send_symbol(32'hffff_ffff, 1'b0);
    send_symbol(32'h0000_0000, 1'b1);
    for (int i = 0; i < 6; i++) send_symbol(32'h5, i == 5);
    send_symbol(32'h1, 1'b0);
    send_symbol(32'h2, 1'b0);
    send_symbol(32'h1, 1'b0);
    send_symbol(32'h2, 1'b1);
    wait_drained();
  endtask

  task automatic test_store_full();
    for (int i = 0; i < StoreDepth + 3; i++) send_symbol(random_symbol(3), i == StoreDepth + 2);
    for (int i = 0; i < StoreDepth; i++) send_symbol($urandom(), i == StoreDepth - 1);
    wait_drained();
  endtask

  task automatic test_random(int strings);
    for (int s = 0; s < strings; s++) begin
      if ($urandom_range(9) == 0) send_string($urandom_range(40, 63), $urandom_range(2, 8));
      else send_string($urandom_range(1, 12), $urandom_range(2, 6));
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    send_string(5, 3);
    send_string(6, 3);
    send_string(4, 2);
    wait_drained();
    send_string(8, 4);
    wait_drained();
    send_string(3, 2);
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    rank_entry_t exp_e;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (ranked_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result transfer: start %0d", suffix_start);
      end else begin
        exp_e = ranked_q.pop_front();
        if (suffix_start !== exp_e.start || common_prefix !== exp_e.prefix ||
            final_rank !== exp_e.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                     exp_e.start, exp_e.prefix, exp_e.last,
                     suffix_start, common_prefix, final_rank);
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    symbol = '0;
    end_of_string = 1'b0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    mismatch_count = 0;
    cycle_count = 0;
    text_len = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_store_full();
    test_random(3);
    send_idle_pct = 45;
    test_random(3);
    send_idle_pct = 0;
    stall_pct = 45;
    test_random(3);
    send_idle_pct = 18;
    stall_pct = 18;
    test_random(3);
    send_idle_pct = 0;
    stall_pct = 0;
    test_backpressure();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && ranked_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== suffix_array_with_lcp.f =====
+incdir+rtl
rtl/sa_pkg.sv
rtl/sa_datapath.sv
rtl/sa_ctrl.sv
rtl/suffix_array_with_lcp.sv
tb/tb_suffix_array_with_lcp.sv
